@@ rtl/tcav_pkg.sv @@
// ============================================================================
// tcav_pkg: shared types and constants of the two-channel ADC voltmeter
// Beat structures, controller command and status groups, register indexes
// and the seven-segment decoder used by the datapath and the checker.
// ============================================================================
`timescale 1ns / 1ps

package tcav_pkg;

    // Fixed field widths of the beats.
    localparam int SAMPLE_W   = 10;
    localparam int AVG_W      = 10;
    localparam int DIGIT_W    = 4;
    localparam int SEG_W      = 8;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int FS_W       = 10;
    localparam int VOLT_W     = 10;

    // Default converter resolution.
    localparam int ADC_BITS_DEFAULT = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] WINDOW_LIMIT_RESET = 16'd2000;
    localparam logic [FS_W-1:0]       FULL_SCALE_RESET   = 10'd500;

    // Largest displayable value in hundredths of a volt.
    localparam logic [VOLT_W-1:0] VOLT_MAX = 10'd999;

    // Decimal point bit of a segment code.
    localparam logic [SEG_W-1:0] SEG_DP = 8'h80;

    typedef struct packed {
        logic                channel;
        logic [SAMPLE_W-1:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic               out_channel;
        logic               no_samples;
        logic [AVG_W-1:0]   average_code;
        logic [DIGIT_W-1:0] ones_digit;
        logic [DIGIT_W-1:0] tenths_digit;
        logic [DIGIT_W-1:0] hundredths_digit;
        logic [SEG_W-1:0]   ones_segments;
        logic [SEG_W-1:0]   tenths_segments;
        logic [SEG_W-1:0]   hundredths_segments;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_check;
        logic div_step;
        logic scale;
        logic split_hundreds;
        logic split_tens;
        logic deliver;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
        logic out_free;
    } dp_status_t;

    // Common-cathode seven-segment code of one decimal digit.
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/two_channel_adc_average_voltmeter_unit.sv @@
// ============================================================================
// two_channel_adc_average_voltmeter_unit: block-average voltmeter, two inputs
// Averages ADC samples per channel over a window and reports the mean as
// volts with three decimal digits and their seven-segment codes.
// ============================================================================
// Usage:
//   Samples enter on the sample channel (valid/ready), each beat carrying a
//   channel tag and a raw ADC code. Every beat bumps one shared counter; the
//   beat that takes it past window_limit closes the window of its channel and
//   produces one result beat with the rounded mean, the voltage digits and
//   their segment codes. The closing sample then starts the new window.
//   A sample that closes no window leaves sample_ready high, so such beats
//   can stream back to back. A closing sample keeps sample_ready low while
//   the controller tests for overflow, runs the restoring divider that forms
//   the mean, does the scaling multiply and the two digit-split steps and
//   loads the output register. The result beat waits in that register.
//   While it waits, further samples are still taken; only a second closing
//   sample stalls, in its last step, until the receiver takes the first
//   result. Reset clears the sums, counts and shared counter and restores
//   window_limit to 2000 and full_scale_hundredths to 500. Configuration is
//   written through cfg_wr_en, cfg_index and cfg_wdata; the user must write
//   it only while the block idles, as the block itself does not enforce
//   this.
// ============================================================================
`timescale 1ns / 1ps

module two_channel_adc_average_voltmeter_unit #(
    parameter int ADC_BITS = tcav_pkg::ADC_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tcav_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcav_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  tcav_pkg::in_beat_t              sample_data,
    output logic                            result_valid,
    input  logic                            result_ready,
    output tcav_pkg::out_beat_t             result_data
);
    import tcav_pkg::*;

    // Command and status groups between the sequencer and the datapath.
    ctl_cmd_t   cmd;
    dp_status_t status;

    // The controller owns sample_ready and the step sequence of a window close.
    tcav_ctrl #(
        .ADC_BITS (ADC_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the configuration, the accumulators, the divider
    // and the output register that decouples the result side.
    tcav_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

@@ rtl/tcav_ctrl.sv @@
// ============================================================================
// tcav_ctrl: sequencing controller of the two-channel ADC voltmeter
// Takes samples, and for a sample that closes a window steps the datapath
// through the check, the serial division, the scaling and the digit split.
// ============================================================================
`timescale 1ns / 1ps

module tcav_ctrl #(
    parameter int ADC_BITS = tcav_pkg::ADC_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  tcav_pkg::dp_status_t status,
    output tcav_pkg::ctl_cmd_t   cmd
);
    import tcav_pkg::*;

    localparam int STEP_W = $clog2(ADC_BITS);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(ADC_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SCALE,
        ST_HUNDREDS,
        ST_TENS,
        ST_DELIVER
    } state_t;

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              ready_reg;
    logic              accept;

    assign sample_ready = ready_reg;
    assign accept       = sample_valid && ready_reg;

    always_comb
    begin
        cmd                = '0;
        cmd.accept         = accept;
        cmd.load_check     = (state_reg == ST_CHECK);
        cmd.div_step       = (state_reg == ST_DIVIDE);
        cmd.scale          = (state_reg == ST_SCALE);
        cmd.split_hundreds = (state_reg == ST_HUNDREDS);
        cmd.split_tens     = (state_reg == ST_TENS);
        cmd.deliver        = (state_reg == ST_DELIVER) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && status.emit)
                    begin
                        state_reg <= ST_CHECK;
                        ready_reg <= 1'b0;
                    end
                end
                ST_CHECK:
                begin
                    step_reg  <= STEP_FIRST;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_SCALE;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                ST_SCALE:
                begin
                    state_reg <= ST_HUNDREDS;
                end
                ST_HUNDREDS:
                begin
                    state_reg <= ST_TENS;
                end
                ST_TENS:
                begin
                    state_reg <= ST_DELIVER;
                end
                ST_DELIVER:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

@@ rtl/tcav_datapath.sv @@
// ============================================================================
// tcav_datapath: accumulators, divider and digit split of the voltmeter
// Holds the configuration, the per-channel sums and counts, a restoring
// divider for the rounded mean, the scaling multiplier and the result beat.
// ============================================================================
`timescale 1ns / 1ps

module tcav_datapath #(
    parameter int ADC_BITS = tcav_pkg::ADC_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [tcav_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcav_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  tcav_pkg::in_beat_t                   sample_data,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output tcav_pkg::out_beat_t                  result_data,
    input  tcav_pkg::ctl_cmd_t                   cmd,
    output tcav_pkg::dp_status_t                 status
);
    import tcav_pkg::*;

    localparam int MASK_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SMP_MASK = SAMPLE_W'((1 << MASK_BITS) - 1);
    localparam int NUM_W  = SUM_W + 1;
    localparam int PROD_W = FS_W + ADC_BITS;

    // Configuration.
    logic [CFG_DATA_W-1:0] window_limit_reg;
    logic [FS_W-1:0]       full_scale_reg;

    // Accumulation state.
    logic [CNT_W-1:0] counter_reg;
    logic [SUM_W-1:0] sum_reg [2];
    logic [CNT_W-1:0] cnt_reg [2];

    // Division and result registers.
    logic                channel_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [CNT_W-1:0]    den_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [ADC_BITS-1:0] quot_reg;
    logic                empty_reg;
    logic                clamp_reg;
    logic [ADC_BITS-1:0] avg_reg;
    logic [VOLT_W-1:0]   volt_reg;
    logic [DIGIT_W-1:0]  d1_reg;
    logic [6:0]          rem1_reg;
    logic [DIGIT_W-1:0]  d2_reg;
    logic [DIGIT_W-1:0]  d3_reg;
    out_beat_t           out_reg;
    logic                out_valid_reg;

    logic                ch;
    logic [SAMPLE_W-1:0] smp;
    logic [CNT_W-1:0]    counter_inc;
    logic                emit;
    logic [SUM_W-1:0]    cur_sum;
    logic [CNT_W-1:0]    cur_cnt;
    logic [NUM_W-1:0]    sum_add;
    logic [SUM_W-1:0]    sum_sat;
    logic [CNT_W-1:0]    cnt_sat;
    logic [NUM_W-1:0]    den_shift;
    logic [CNT_W:0]      trial;
    logic                trial_ge;
    logic [ADC_BITS-1:0] avg_sel;
    logic [PROD_W-1:0]   prod;
    logic [VOLT_W-1:0]   volt_raw;
    logic [15:0]         hund_prod;
    logic [DIGIT_W-1:0]  d1;
    logic [VOLT_W-1:0]   rem1_wide;
    logic [13:0]         tens_prod;
    logic [DIGIT_W-1:0]  d2;
    logic [6:0]          d3_wide;
    out_beat_t           out_next;

    // Sample side: shared counter test and saturating accumulation.
    assign ch          = sample_data.channel;
    assign smp         = sample_data.sample & SMP_MASK;
    assign counter_inc = counter_reg + 1'b1;
    assign emit        = counter_inc > window_limit_reg;
    assign cur_sum     = sum_reg[ch];
    assign cur_cnt     = cnt_reg[ch];
    assign sum_add     = {1'b0, cur_sum} + NUM_W'(smp);
    assign sum_sat     = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign cnt_sat     = (cur_cnt == {CNT_W{1'b1}}) ? cur_cnt : cur_cnt + 1'b1;

    // A quotient of 2^ADC_BITS or more is clamped, so only ADC_BITS bits are
    // developed by the divider.
    assign den_shift = NUM_W'(den_reg) << ADC_BITS;
    assign trial     = {rem_reg, quot_reg[ADC_BITS-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};

    always_comb
    begin
        if (empty_reg)
        begin
            avg_sel = '0;
        end
        else if (clamp_reg)
        begin
            avg_sel = '1;
        end
        else
        begin
            avg_sel = quot_reg;
        end
    end

    assign prod     = PROD_W'(full_scale_reg) * PROD_W'(avg_sel);
    assign volt_raw = prod[PROD_W-1:ADC_BITS];

    // Digit split by reciprocal multiplication; exact for values below 1000.
    assign hund_prod = 16'(volt_reg) * 16'd41;
    assign d1        = hund_prod[15:12];
    assign rem1_wide = volt_reg - VOLT_W'(d1) * VOLT_W'(100);
    assign tens_prod = 14'(rem1_reg) * 14'd103;
    assign d2        = tens_prod[13:10];
    assign d3_wide   = rem1_reg - 7'(d2) * 7'd10;

    always_comb
    begin
        out_next                     = '0;
        out_next.out_channel         = channel_reg;
        out_next.no_samples          = empty_reg;
        out_next.average_code        = AVG_W'(avg_reg);
        out_next.ones_digit          = d1_reg;
        out_next.tenths_digit        = d2_reg;
        out_next.hundredths_digit    = d3_reg;
        out_next.ones_segments       = seg_code(d1_reg) | SEG_DP;
        out_next.tenths_segments     = seg_code(d2_reg);
        out_next.hundredths_segments = seg_code(d3_reg);
    end

    assign status.emit     = emit;
    assign status.out_free = !out_valid_reg || result_ready;
    assign result_valid    = out_valid_reg;
    assign result_data     = out_reg;

    // Configuration and accumulation state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg <= WINDOW_LIMIT_RESET;
            full_scale_reg   <= FULL_SCALE_RESET;
            counter_reg      <= '0;
            sum_reg[0]       <= '0;
            sum_reg[1]       <= '0;
            cnt_reg[0]       <= '0;
            cnt_reg[1]       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_WINDOW_LIMIT: window_limit_reg <= cfg_wdata;
                    REG_FULL_SCALE:   full_scale_reg   <= cfg_wdata[FS_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.accept)
            begin
                if (emit)
                begin
                    counter_reg <= '0;
                    sum_reg[ch] <= SUM_W'(smp);
                    cnt_reg[ch] <= CNT_W'(1);
                end
                else
                begin
                    counter_reg <= counter_inc;
                    sum_reg[ch] <= sum_sat;
                    cnt_reg[ch] <= cnt_sat;
                end
            end
        end
    end

    // Payload registers of the division and the digit split.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && emit)
        begin
            channel_reg <= ch;
            num_reg     <= {1'b0, cur_sum} + NUM_W'(cur_cnt >> 1);
            den_reg     <= cur_cnt;
        end
        if (cmd.load_check)
        begin
            empty_reg <= (den_reg == '0);
            clamp_reg <= (num_reg >= den_shift);
            rem_reg   <= num_reg[ADC_BITS +: CNT_W];
            quot_reg  <= num_reg[ADC_BITS-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
            quot_reg <= {quot_reg[ADC_BITS-2:0], trial_ge};
        end
        if (cmd.scale)
        begin
            avg_reg  <= avg_sel;
            volt_reg <= (volt_raw > VOLT_MAX) ? VOLT_MAX : volt_raw;
        end
        if (cmd.split_hundreds)
        begin
            d1_reg   <= d1;
            rem1_reg <= rem1_wide[6:0];
        end
        if (cmd.split_tens)
        begin
            d2_reg <= d2;
            d3_reg <= d3_wide[DIGIT_W-1:0];
        end
        if (cmd.deliver)
        begin
            out_reg <= out_next;
        end
    end

    // Output beat valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.deliver)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/tcav_checker.sv @@
// ============================================================================
// tcav_checker: port-level checks of the two-channel ADC voltmeter
// Watches the result channel for a held beat and for consistent digits and
// segment codes; bound to the top level.
// ============================================================================
`timescale 1ns / 1ps

module tcav_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input tcav_pkg::out_beat_t result_data
);
    import tcav_pkg::*;

    // A stalled result beat stays in place.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result beat changed while stalled");

    // An empty window reports zero mean and zero digits.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.no_samples |->
            result_data.average_code == '0 && result_data.ones_digit == '0 &&
            result_data.tenths_digit == '0 && result_data.hundredths_digit == '0)
        else $error("empty window reported nonzero value");

    // Digits stay decimal.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.ones_digit <= 4'd9 &&
            result_data.tenths_digit <= 4'd9 && result_data.hundredths_digit <= 4'd9)
        else $error("digit out of decimal range");

    // Segment codes follow their digits, with the point on the ones digit.
    a_segments: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result_data.ones_segments == (seg_code(result_data.ones_digit) | SEG_DP) &&
            result_data.tenths_segments == seg_code(result_data.tenths_digit) &&
            result_data.hundredths_segments == seg_code(result_data.hundredths_digit))
        else $error("segment code does not match digit");

endmodule

bind two_channel_adc_average_voltmeter_unit tcav_checker u_tcav_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);
